/* rtl/core/trial_division_prime_test_top_defines.svh */
// assertion macros for the trial division prime test
`ifndef TRIAL_DIVISION_PRIME_TEST_TOP_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TDPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TDPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/tdpt_pkg.sv */
`timescale 1ns / 1ps

package tdpt_pkg;

  localparam int unsigned FIRST_DIV = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BOUND,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_stat_t;

endpackage

/* rtl/core/trial_division_prime_test_top.sv */
`timescale 1ns / 1ps
// channel   ports                                   handshake
// input     in_candidate                            start high, busy low
// result    out_value, out_is_prime                 out_valid, one cycle, no stall
//
// each beat checks the bound and runs a serial remainder per trial divisor tried, then shows the result
// the serial remainder unit sets the pace: one dividend bit per cycle
// about 10000 divisors are tried for an eight-digit prime
// rst_n is synchronous and active low; no clearing pass is needed
// busy stays high from the accepted beat until the result cycle ends

`include "trial_division_prime_test_top_defines.svh"

module trial_division_prime_test_top #(
  parameter int NUM_WIDTH = 27
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [NUM_WIDTH-1:0] in_candidate,
  output logic                 out_valid,
  output logic [NUM_WIDTH-1:0] out_value,
  output logic                 out_is_prime
);

  localparam int DW  = (NUM_WIDTH + 1) / 2 + 1;
  localparam int SQW = NUM_WIDTH + 1;

  tdpt_pkg::state_t    state_r, state_nxt;
  tdpt_pkg::div_stat_t div_stat;

  logic [NUM_WIDTH-1:0] n_r, n_nxt;
  logic [DW-1:0]        d_r, d_nxt;
  logic [SQW-1:0]       sq_r, sq_nxt;
  logic                 prime_r, prime_nxt;
  logic                 over_bound;
  logic                 small_cand;
  logic                 div_go;

  assign over_bound = sq_r > {1'b0, n_r};
  assign small_cand = in_candidate < NUM_WIDTH'(tdpt_pkg::FIRST_DIV);

  tdpt_rem_unit #(
    .NUM_WIDTH (NUM_WIDTH)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (n_r),
    .divisor  (d_r),
    .stat     (div_stat)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tdpt_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = small_cand ? tdpt_pkg::ST_DONE : tdpt_pkg::ST_BOUND;
        end
      end
      tdpt_pkg::ST_BOUND: begin
        state_nxt = over_bound ? tdpt_pkg::ST_DONE : tdpt_pkg::ST_DIV;
      end
      tdpt_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = div_stat.rem_zero ? tdpt_pkg::ST_DONE : tdpt_pkg::ST_BOUND;
        end
      end
      tdpt_pkg::ST_DONE: state_nxt = tdpt_pkg::ST_IDLE;
      default:           state_nxt = tdpt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state_r != tdpt_pkg::ST_IDLE);
    out_valid = (state_r == tdpt_pkg::ST_DONE);
    div_go    = (state_r == tdpt_pkg::ST_BOUND) && !over_bound;
  end

  // datapath next values; (d+1)^2 = d^2 + 2d + 1
  always_comb begin
    n_nxt     = n_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    prime_nxt = prime_r;
    case (state_r)
      tdpt_pkg::ST_IDLE: begin
        if (start) begin
          n_nxt     = in_candidate;
          d_nxt     = DW'(tdpt_pkg::FIRST_DIV);
          sq_nxt    = SQW'(tdpt_pkg::FIRST_DIV * tdpt_pkg::FIRST_DIV);
          prime_nxt = 1'b0;
        end
      end
      tdpt_pkg::ST_BOUND: begin
        if (over_bound) begin
          prime_nxt = 1'b1;
        end
      end
      tdpt_pkg::ST_DIV: begin
        if (div_stat.done) begin
          d_nxt  = d_r + DW'(1);
          sq_nxt = sq_r + SQW'({d_r, 1'b0}) + SQW'(1);
        end
      end
      default: begin
        prime_nxt = prime_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdpt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    d_r     <= d_nxt;
    sq_r    <= sq_nxt;
    prime_r <= prime_nxt;
  end

  assign out_value    = n_r;
  assign out_is_prime = prime_r;

  `TDPT_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted beat did not raise busy")
  `TDPT_ASSERT_NEXT(a_strobe_once, out_valid, !out_valid && !busy, "result strobe not single")
  `TDPT_ASSERT_NOW(a_small_not_prime,
                   out_valid && (out_value == '0 || out_value == NUM_WIDTH'(1)),
                   !out_is_prime, "zero or one flagged prime")
  `TDPT_ASSERT_NOW(a_go_idle_unit, div_go,
                   state_r == tdpt_pkg::ST_BOUND && !div_stat.done,
                   "divide launched out of sequence")

endmodule

/* rtl/core/tdpt_rem_unit.sv */
`timescale 1ns / 1ps

module tdpt_rem_unit #(
  parameter int NUM_WIDTH = 27
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [NUM_WIDTH-1:0]          dividend,
  input  logic [(NUM_WIDTH+1)/2:0]      divisor,
  output tdpt_pkg::div_stat_t           stat
);

  localparam int DW = (NUM_WIDTH + 1) / 2 + 1;
  localparam int CW = $clog2(NUM_WIDTH + 1);

  logic          active_r, active_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NUM_WIDTH-1:0] sh_r, sh_nxt;
  logic [DW-1:0] div_r, div_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW:0]   rem_sh;
  logic [DW+1:0] diff;

  // one restoring step per cycle, dividend bits taken msb first
  assign rem_sh = {rem_r, sh_r[NUM_WIDTH-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, div_r};

  always_comb begin
    active_nxt = active_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    sh_nxt     = sh_r;
    div_nxt    = div_r;
    rem_nxt    = rem_r;
    if (go) begin
      active_nxt = 1'b1;
      cnt_nxt    = CW'(NUM_WIDTH);
      sh_nxt     = dividend;
      div_nxt    = divisor;
      rem_nxt    = '0;
    end else if (active_r) begin
      sh_nxt  = {sh_r[NUM_WIDTH-2:0], 1'b0};
      rem_nxt = diff[DW+1] ? rem_sh[DW-1:0] : diff[DW-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.done     = done_r;
  assign stat.rem_zero = (rem_r == '0);

endmodule

/* verif/prime_verdict_checker.sv */
`timescale 1ns / 1ps

module prime_verdict_checker #(
  parameter int NUM_WIDTH = 27
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [NUM_WIDTH-1:0] in_candidate,
  input  logic                 out_valid,
  input  logic [NUM_WIDTH-1:0] out_value,
  input  logic                 out_is_prime,
  output int                   mismatch_count,
  output int                   verdicts_owed
);

  typedef struct {
    logic [NUM_WIDTH-1:0] value;
    logic                 is_prime;
  } verdict_t;

  verdict_t owed_verdicts[$];
  int       err_cnt   = 0;
  int       owed_cnt  = 0;

  assign mismatch_count = err_cnt;
  assign verdicts_owed  = owed_cnt;

  function automatic logic trial_prime(input logic [NUM_WIDTH-1:0] n);
    longint unsigned num;
    longint unsigned d;
    num = n;
    if (num < 2) return 1'b0;
    for (d = 2; d * d <= num; d++) begin
      if (num % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch_beats
    verdict_t want;
    verdict_t fresh;
    if (rst_n) begin
      if (out_valid) begin
        if (owed_verdicts.size() == 0) begin
          $error("out_value %0d / out_is_prime %0d with no beat outstanding",
                 out_value, out_is_prime);
          err_cnt++;
        end else begin
          want = owed_verdicts.pop_front();
          if (out_value !== want.value) begin
            $error("out_value: expected %0d, actual %0d", want.value, out_value);
            err_cnt++;
          end
          if (out_is_prime !== want.is_prime) begin
            $error("out_is_prime: expected %0d, actual %0d (value %0d)",
                   want.is_prime, out_is_prime, want.value);
            err_cnt++;
          end
        end
      end
      if (start && !busy) begin
        fresh.value    = in_candidate;
        fresh.is_prime = trial_prime(in_candidate);
        owed_verdicts.push_back(fresh);
      end
      owed_cnt <= owed_verdicts.size();
    end
  end

endmodule

/* verif/trial_division_prime_test_top_tb.sv */
`timescale 1ns / 1ps

module trial_division_prime_test_top_tb;

  localparam int NUM_WIDTH   = 27;
  localparam int STALL_LIMIT = 1500000;
  localparam int RANDOM_BEATS = 100;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [NUM_WIDTH-1:0] in_candidate;
  logic                 out_valid;
  logic [NUM_WIDTH-1:0] out_value;
  logic                 out_is_prime;

  int mismatch_count;
  int verdicts_owed;
  int idle_pct;
  int stall_cycles = 0;

  logic [NUM_WIDTH-1:0] directed_cands[] = '{
    27'd0, 27'd1, 27'd2, 27'd3, 27'd4, 27'd5, 27'd9, 27'd25, 27'd49, 27'd97,
    27'd121, 27'd63001, 27'd65521, 27'd1000003, 27'd67108864, 27'd99999999,
    27'd100000000, 27'd134217726, 27'd134217727, 27'd134217689
  };

  trial_division_prime_test_top #(
    .NUM_WIDTH(NUM_WIDTH)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_candidate(in_candidate),
    .out_valid   (out_valid),
    .out_value   (out_value),
    .out_is_prime(out_is_prime)
  );

  prime_verdict_checker #(
    .NUM_WIDTH(NUM_WIDTH)
  ) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_candidate  (in_candidate),
    .out_valid     (out_valid),
    .out_value     (out_value),
    .out_is_prime  (out_is_prime),
    .mismatch_count(mismatch_count),
    .verdicts_owed (verdicts_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // small numbers mostly; full-width ones get a small factor to keep runs short
  function automatic logic [NUM_WIDTH-1:0] pick_candidate();
    int unsigned          roll;
    int unsigned          factor;
    logic [NUM_WIDTH-1:0] raw;
    roll = $urandom_range(99);
    if (roll < 55) return NUM_WIDTH'($urandom_range(4095));
    if (roll < 75) return NUM_WIDTH'($urandom_range((1 << 20) - 1));
    raw    = NUM_WIDTH'($urandom);
    factor = $urandom_range(13, 2);
    return raw - NUM_WIDTH'(raw % factor);
  endfunction

  // entered and left at a falling edge; start is left high after the beat
  task automatic send_candidate(input logic [NUM_WIDTH-1:0] cand);
    while ($urandom_range(99) < idle_pct) begin
      start        <= 1'b0;
      in_candidate <= NUM_WIDTH'($urandom);
      @(negedge clk);
    end
    start        <= 1'b1;
    in_candidate <= cand;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain_verdicts();
    start <= 1'b0;
    while (verdicts_owed != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_candidate = '0;
    idle_pct     = 27;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_cands[i]) send_candidate(directed_cands[i]);

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == RANDOM_BEATS / 3) begin
        drain_verdicts();
        idle_pct = 72;
      end else if (i == 2 * RANDOM_BEATS / 3) begin
        drain_verdicts();
        idle_pct = 0;
      end
      send_candidate(pick_candidate());
    end

    drain_verdicts();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
